// ===== design/rgse_pkg.sv =====
package rgse_pkg;

  localparam int unsigned PixW = 8;
  localparam int unsigned CfgW = 12;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned PaddrW = 3;

  localparam int unsigned DefMaxWidth = 2048;
  localparam int unsigned DefMaxHeight = 2048;
  localparam int unsigned MinSize = 3;

  localparam logic [CfgW-1:0] ResetWidth = 12'd640;
  localparam logic [CfgW-1:0] ResetHeight = 12'd480;

  // register index, taken from paddr[2]
  typedef enum logic {
    RegFrameWidth  = 1'b0,
    RegFrameHeight = 1'b1
  } reg_idx_e;

  localparam logic [7:0] CoefRed = 8'd77;
  localparam logic [7:0] CoefGreen = 8'd150;
  localparam logic [7:0] CoefBlue = 8'd29;
  localparam logic [PixW-1:0] MagMax = 8'd255;

  // 3x3 gray window, [row][col], row 0 is the oldest line
  typedef logic [2:0][2:0][PixW-1:0] window_t;

endpackage

// ===== design/rgse_pix_if.sv =====
interface rgse_pix_if;
  import rgse_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] red;
  logic [PixW-1:0] green;
  logic [PixW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== design/rgse_edge_if.sv =====
interface rgse_edge_if;
  import rgse_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] edge_magnitude;
  logic            end_of_row;
  logic            end_of_frame;

  modport source (output valid, output edge_magnitude, output end_of_row,
                  output end_of_frame, input ready);
  modport sink (input valid, input edge_magnitude, input end_of_row,
                input end_of_frame, output ready);
endinterface

// ===== design/rgb_gray_sobel_edge_stream.sv =====
// Stages: input stage, window stage, output register. The result of a window
//   is sent for the pixel that completes it. Throughput: one pixel per cycle
//   while edge_o.ready does not stall the output; each line buffer does one read
//   and one write per cycle. Border pixels are taken at that rate, giving no result.
// Reset: positions, window and valid flags clear, sizes go to 640 x 480.
//   Line buffers are not cleared; they are written before they are read.
module rgb_gray_sobel_edge_stream #(
  parameter int unsigned MAX_WIDTH  = rgse_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = rgse_pkg::DefMaxHeight
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rgse_pix_if.sink                       pix_i,
  rgse_edge_if.source                    edge_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rgse_pkg::PaddrW-1:0]    paddr,
  input  logic [rgse_pkg::ApbDataW-1:0]  pwdata,
  output logic [rgse_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import rgse_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);
  localparam int unsigned XW = (CfgW > ColW + 1) ? CfgW : ColW + 1;
  localparam int unsigned YW = (CfgW > RowW + 1) ? CfgW : RowW + 1;
  localparam int unsigned SumW = PixW + 2;

  // configuration
  logic [CfgW-1:0] width_q, height_q;
  reg_idx_e        reg_idx;
  logic            cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PaddrW-1]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegFrameWidth:  width_q  <= pwdata[CfgW-1:0];
        RegFrameHeight: height_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegFrameWidth:  prdata = ApbDataW'(width_q);
      RegFrameHeight: prdata = ApbDataW'(height_q);
      default:        prdata = '0;
    endcase
  end

  // clamped sizes
  logic [XW-1:0] w_ext, w_eff;
  logic [YW-1:0] h_ext, h_eff;

  always_comb begin
    w_ext = XW'(width_q);
    h_ext = YW'(height_q);
    if (w_ext < XW'(MinSize))        w_eff = XW'(MinSize);
    else if (w_ext > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
    else                             w_eff = w_ext;
    if (h_ext < YW'(MinSize))         h_eff = YW'(MinSize);
    else if (h_ext > YW'(MAX_HEIGHT)) h_eff = YW'(MAX_HEIGHT);
    else                              h_eff = h_ext;
  end

  // handshake chain
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_adv, s2_adv, in_acc;

  assign s2_adv       = s2_valid_q & (~out_valid_q | edge_o.ready);
  assign s1_adv       = s1_valid_q & (~s2_valid_q | s2_adv);
  assign pix_i.ready  = ~s1_valid_q | s1_adv;
  assign in_acc       = pix_i.valid & pix_i.ready;

  // raster position
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            row_end, frame_end, interior;

  assign row_end   = (XW'(col_q) + XW'(1)) >= w_eff;
  assign frame_end = row_end & ((YW'(row_q) + YW'(1)) >= h_eff);
  assign interior  = (row_q >= RowW'(2)) & (col_q >= ColW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_end ? '0 : row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end
  end

  // input stage
  logic [ColW-1:0] s1_col_q;
  logic [PixW-1:0] s1_red_q, s1_green_q, s1_blue_q;
  logic            s1_eor_q, s1_eof_q, s1_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      s1_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_col_q   <= col_q;
      s1_red_q   <= pix_i.red;
      s1_green_q <= pix_i.green;
      s1_blue_q  <= pix_i.blue;
      s1_eor_q   <= row_end;
      s1_eof_q   <= frame_end;
      s1_int_q   <= interior;
    end
  end

  // line buffers: lb0 holds the previous row, lb1 the one before
  logic [PixW-1:0] lb0_mem [MAX_WIDTH];
  logic [PixW-1:0] lb1_mem [MAX_WIDTH];
  logic [PixW-1:0] above_q, above2_q;
  logic [PixW-1:0] gray;
  logic [2*PixW-1:0] gray_sum;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_q  <= lb0_mem[col_q];
      above2_q <= lb1_mem[col_q];
    end
    if (s1_adv) begin
      lb0_mem[s1_col_q] <= gray;
      lb1_mem[s1_col_q] <= above_q;
    end
  end

  assign gray_sum = (2*PixW)'(CoefRed) * (2*PixW)'(s1_red_q)
                  + (2*PixW)'(CoefGreen) * (2*PixW)'(s1_green_q)
                  + (2*PixW)'(CoefBlue) * (2*PixW)'(s1_blue_q);
  assign gray = gray_sum[2*PixW-1:PixW];

  // window stage
  window_t window_q;
  logic    s2_eor_q, s2_eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        for (int i = 0; i < 3; i++) begin
          window_q[i][0] <= window_q[i][1];
          window_q[i][1] <= window_q[i][2];
        end
        window_q[0][2] <= above2_q;
        window_q[1][2] <= above_q;
        window_q[2][2] <= gray;
      end
      if (s1_adv) begin
        s2_valid_q <= s1_int_q;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_eor_q <= s1_eor_q;
      s2_eof_q <= s1_eof_q;
    end
  end

  // Sobel magnitude
  logic [SumW-1:0] gx_pos, gx_neg, gy_pos, gy_neg, gx_abs, gy_abs;
  logic [SumW:0]   mag;
  logic [PixW-1:0] mag_sat;

  always_comb begin
    gx_pos = SumW'(window_q[0][2]) + {1'b0, window_q[1][2], 1'b0} + SumW'(window_q[2][2]);
    gx_neg = SumW'(window_q[0][0]) + {1'b0, window_q[1][0], 1'b0} + SumW'(window_q[2][0]);
    gy_pos = SumW'(window_q[2][0]) + {1'b0, window_q[2][1], 1'b0} + SumW'(window_q[2][2]);
    gy_neg = SumW'(window_q[0][0]) + {1'b0, window_q[0][1], 1'b0} + SumW'(window_q[0][2]);
    gx_abs = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    gy_abs = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
    mag    = (SumW+1)'(gx_abs) + (SumW+1)'(gy_abs);
    mag_sat = (mag > (SumW+1)'(MagMax)) ? MagMax : mag[PixW-1:0];
  end

  // output register
  logic [PixW-1:0] mag_q;
  logic            eor_q, eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= 1'b1;
    end else if (edge_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      mag_q <= mag_sat;
      eor_q <= s2_eor_q;
      eof_q <= s2_eof_q;
    end
  end

  assign edge_o.valid          = out_valid_q;
  assign edge_o.edge_magnitude = mag_q;
  assign edge_o.end_of_row     = eor_q;
  assign edge_o.end_of_frame   = eof_q;

  // checks
  a_eof_has_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!eof_q || eor_q))
    else $error("end_of_frame without end_of_row");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (XW'(col_q) < XW'(MAX_WIDTH)) && (YW'(row_q) < YW'(MAX_HEIGHT)))
    else $error("raster position out of range");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && row_end) |=> (col_q == '0))
    else $error("column did not wrap at row end");

  a_no_result_on_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_int_q) |=> !s2_valid_q)
    else $error("border pixel produced a result");

  a_in_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> pix_i.ready)
    else $error("input stalled with empty input stage");

endmodule

// ===== tb/rgb_gray_sobel_edge_stream_test.sv =====
module rgb_gray_sobel_edge_stream_test;
  import rgse_pkg::*;

  localparam int unsigned MaxW = DefMaxWidth;
  localparam int unsigned MaxH = DefMaxHeight;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned RandomPixels = 1020;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [PixW-1:0] magnitude;
    logic            row_last;
    logic            frame_last;
  } edge_t;

  typedef enum int {
    PatNoise,
    PatExtreme,
    PatFlat,
    PatSplit,
    PatRamp
  } pattern_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic pready;

  rgse_pix_if pix_if ();
  rgse_edge_if edge_if ();

  rgb_gray_sobel_edge_stream #(
    .MAX_WIDTH (MaxW),
    .MAX_HEIGHT(MaxH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .edge_o (edge_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [CfgW-1:0] width_reg = ResetWidth;
  logic [CfgW-1:0] height_reg = ResetHeight;
  logic [PixW-1:0] line_recent [MaxW] = '{default: '0};
  logic [PixW-1:0] line_older [MaxW] = '{default: '0};
  window_t win = '0;
  logic [10:0] col_pos = '0;
  logic [10:0] row_pos = '0;

  rgb_t pixel_backlog [$];
  edge_t pending_edges [$];

  int src_idle = 0;
  int snk_idle = 0;
  int mismatches = 0;
  int reg_errors = 0;
  int pixels_sent = 0;
  int edges_checked = 0;
  int frames_run = 0;
  int stall_cycles = 0;

  rgb_t cur_px;
  rgb_t next_px;
  edge_t got_edge;
  edge_t want_edge;

  function automatic int unsigned clamp_size(logic [CfgW-1:0] v, int unsigned hi);
    if (v < MinSize) return MinSize;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic sobel_take_pixel(input rgb_t px);
    logic [15:0] weighted;
    logic [PixW-1:0] gray;
    logic [PixW-1:0] above;
    logic [PixW-1:0] above2;
    int unsigned w_eff;
    int unsigned h_eff;
    int gx;
    int gy;
    int mag;
    logic row_end;
    logic frame_end;
    edge_t res;
    w_eff = clamp_size(width_reg, MaxW);
    h_eff = clamp_size(height_reg, MaxH);
    weighted = 16'(CoefRed) * 16'(px.red) + 16'(CoefGreen) * 16'(px.green)
             + 16'(CoefBlue) * 16'(px.blue);
    gray = weighted[15:8];
    above = line_recent[col_pos];
    above2 = line_older[col_pos];
    line_older[col_pos] = above;
    line_recent[col_pos] = gray;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = above2;
    win[1][2] = above;
    win[2][2] = gray;
    row_end = (int'(col_pos) + 1 >= int'(w_eff));
    frame_end = row_end && (int'(row_pos) + 1 >= int'(h_eff));
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
      gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
      mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
      if (mag > int'(MagMax)) mag = int'(MagMax);
      res.magnitude = PixW'(mag);
      res.row_last = row_end;
      res.frame_last = frame_end;
      pending_edges.push_back(res);
    end
    if (row_end) begin
      col_pos = '0;
      row_pos = frame_end ? '0 : row_pos + 11'd1;
    end else begin
      col_pos = col_pos + 11'd1;
    end
  endtask

  // pixel driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        cur_px = {pix_if.red, pix_if.green, pix_if.blue};
        sobel_take_pixel(cur_px);
        pixels_sent++;
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (pixel_backlog.size() != 0 && $urandom_range(99) >= src_idle) begin
          next_px = pixel_backlog.pop_front();
          pix_if.valid <= 1'b1;
          pix_if.red <= next_px.red;
          pix_if.green <= next_px.green;
          pix_if.blue <= next_px.blue;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // edge result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      edge_if.ready <= 1'b0;
    end else begin
      edge_if.ready <= ($urandom_range(99) >= snk_idle);
      if (edge_if.valid && edge_if.ready) begin
        got_edge = {edge_if.edge_magnitude, edge_if.end_of_row, edge_if.end_of_frame};
        if (pending_edges.size() == 0) begin
          if (mismatches + reg_errors < 10)
            $display("unexpected edge result: mag %0d eor %0b eof %0b",
                     got_edge.magnitude, got_edge.row_last, got_edge.frame_last);
          mismatches++;
        end else begin
          want_edge = pending_edges.pop_front();
          edges_checked++;
          if (got_edge.magnitude !== want_edge.magnitude
              || got_edge.row_last !== want_edge.row_last
              || got_edge.frame_last !== want_edge.frame_last) begin
            if (mismatches + reg_errors < 10)
              $display("edge #%0d: exp mag %0d eor %0b eof %0b, got mag %0d eor %0b eof %0b",
                       edges_checked, want_edge.magnitude, want_edge.row_last,
                       want_edge.frame_last, got_edge.magnitude, got_edge.row_last,
                       got_edge.frame_last);
            mismatches++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (edge_if.valid && edge_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 StallLimit, pending_edges.size());
        $display("rgb_gray_sobel_edge_stream_test: errors");
        $finish;
      end
    end
  end

  task automatic reg_write(input reg_idx_e idx, input logic [CfgW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {20'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == RegFrameWidth) width_reg = value;
    else height_reg = value;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_read(input reg_idx_e idx, input logic [CfgW-1:0] want);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[CfgW-1:0] !== want) begin
      if (mismatches + reg_errors < 10)
        $display("register %s readback: exp %0d, got %0d", idx.name(), want,
                 prdata[CfgW-1:0]);
      reg_errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pixel_backlog.size() != 0 || pix_if.valid || pending_edges.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_frame(input logic [CfgW-1:0] w_reg, input logic [CfgW-1:0] h_reg,
                           input pattern_e pat, output int count);
    int unsigned w_eff;
    int unsigned h_eff;
    rgb_t base;
    rgb_t px;
    int kx;
    int ky;
    logic [PixW-1:0] lvl;
    wait_idle();
    reg_write(RegFrameWidth, w_reg);
    reg_write(RegFrameHeight, h_reg);
    reg_read(RegFrameWidth, w_reg);
    reg_read(RegFrameHeight, h_reg);
    w_eff = clamp_size(w_reg, MaxW);
    h_eff = clamp_size(h_reg, MaxH);
    base = rgb_t'($urandom);
    kx = $urandom_range(0, 24);
    ky = $urandom_range(0, 24);
    for (int r = 0; r < int'(h_eff); r++) begin
      for (int c = 0; c < int'(w_eff); c++) begin
        case (pat)
          PatNoise: px = rgb_t'($urandom);
          PatExtreme: px = {{PixW{$urandom_range(1) == 1}}, {PixW{$urandom_range(1) == 1}},
                            {PixW{$urandom_range(1) == 1}}};
          PatFlat: px = base;
          PatSplit: begin
            lvl = ((c < int'(w_eff) / 2) ^ (r[0] & kx[0])) ? '1 : '0;
            px = {lvl, lvl, lvl};
          end
          default: begin
            lvl = PixW'(kx * c + ky * r + $urandom_range(0, 3));
            px = {lvl, lvl, lvl};
          end
        endcase
        pixel_backlog.push_back(px);
      end
    end
    frames_run++;
    count = int'(w_eff * h_eff);
  endtask

  initial begin
    int n;
    int small_pixels;
    int pick;
    logic [CfgW-1:0] w_reg;
    logic [CfgW-1:0] h_reg;
    small_pixels = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    reg_read(RegFrameWidth, ResetWidth);
    reg_read(RegFrameHeight, ResetHeight);

    // smallest frames: saturated split, then flat and extreme with clamped sizes
    src_idle <= 38;
    snk_idle <= 57;
    run_frame(12'd3, 12'd3, PatSplit, n);
    run_frame(12'd0, 12'd1, PatFlat, n);
    run_frame(12'd2, 12'd0, PatExtreme, n);

    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      src_idle <= (phase == 0) ? 38 : (phase == 1) ? 57 : 0;
      snk_idle <= (phase == 0) ? 57 : (phase == 1) ? 38 : 0;
      while (small_pixels < (phase + 1) * int'(RandomPixels) / 3) begin
        pick = $urandom_range(99);
        if (pick < 8) w_reg = CfgW'($urandom_range(0, 2));
        else if (pick < 15) w_reg = CfgW'($urandom_range(15, 40));
        else w_reg = CfgW'($urandom_range(3, 14));
        pick = $urandom_range(99);
        if (pick < 8) h_reg = CfgW'($urandom_range(0, 2));
        else h_reg = CfgW'($urandom_range(3, 7));
        run_frame(w_reg, h_reg, pattern_e'($urandom_range(0, 4)), n);
        small_pixels += n;
      end
    end

    wait_idle();
    $display("run covered %0d frames, %0d pixel transactions, %0d edge results checked",
             frames_run, pixels_sent, edges_checked);
    $display("sizes 3x3 up to 40x7, clamped small register values, three idle mixes");
    if (mismatches + reg_errors == 0) begin
      $display("rgb_gray_sobel_edge_stream_test: clean");
    end else begin
      $display("%0d mismatches", mismatches + reg_errors);
      $display("rgb_gray_sobel_edge_stream_test: errors");
    end
    $finish;
  end

endmodule

// ===== rgb_gray_sobel_edge_stream.f =====
design/rgse_pkg.sv
design/rgse_pix_if.sv
design/rgse_edge_if.sv
design/rgb_gray_sobel_edge_stream.sv
tb/rgb_gray_sobel_edge_stream_test.sv
